FILE: rtl/core/ir_pulse_interval_command_decoder_defines.svh
// ----------------------------------------------------------------------------
// IR pulse interval command decoder - assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i; IRPICD_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_INTERVAL_COMMAND_DECODER_DEFINES_SVH
`define IR_PULSE_INTERVAL_COMMAND_DECODER_DEFINES_SVH

// Checked only out of reset.
`define IRPICD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define IRPICD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/irpicd_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse interval command decoder - package
// Item types, register indexes and command codes.
// ----------------------------------------------------------------------------
package irpicd_pkg;

  localparam int unsigned IntervalW = 20;
  localparam int unsigned SlotW     = 6;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic KindEdge    = 1'b0;
  localparam logic KindTimeout = 1'b1;

  localparam logic [7:0] CmdUp   = 8'd64;
  localparam logic [7:0] CmdDown = 8'd67;
  localparam logic [7:0] CmdMark = 8'd70;
  localparam logic [7:0] CmdMode = 8'd69;

  localparam logic [IntervalW-1:0] StartMinRst = 20'd10000;
  localparam logic [IntervalW-1:0] StartMaxRst = 20'd14000;
  localparam logic [IntervalW-1:0] OneMinRst   = 20'd2000;
  localparam logic [IntervalW-1:0] OneMaxRst   = 20'd2300;
  localparam logic [7:0]           StepRst     = 8'd3;
  localparam logic [7:0]           SpeedRst    = 8'd9;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MIN  = 3'd0,
    CFG_START_MAX  = 3'd1,
    CFG_ONE_MIN    = 3'd2,
    CFG_ONE_MAX    = 3'd3,
    CFG_SPEED_STEP = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                 kind;
    logic [IntervalW-1:0] interval;
  } in_item_t;

  typedef struct packed {
    logic       frame_valid;
    logic [7:0] command;
    logic [7:0] speed_level;
    logic       run_mode;
    logic [3:0] indicators;
  } out_item_t;

  // Frame capture state as seen by the command stage.
  typedef struct packed {
    logic [IntervalW-1:0] start_interval;
    logic [7:0]           bit_classes;
  } frame_t;

endpackage

FILE: rtl/core/ir_pulse_interval_command_decoder.sv
// ----------------------------------------------------------------------------
// IR pulse interval command decoder - top level
// Decodes NEC-style frames from edge interval and timeout items and applies
// the command to speed, mode and sticky indicators.
// ----------------------------------------------------------------------------
// One item is taken every cycle while in_stall_o is low. Each item sits in an
// input register and is resolved there against the frame capture state; a
// timeout's result is written into the output register as the timeout leaves
// the input register. Edge items never wait; a timeout holds the input
// register, and so stalls the input, only while the output register is full
// and stalled. Registers must be written by the user through the config port
// only while the block is idle; the block itself does not enforce this.
// cfg_ready_o is always high and unused indexes are dropped.
`include "ir_pulse_interval_command_decoder_defines.svh"

module ir_pulse_interval_command_decoder #(
  parameter int unsigned FRAME_SLOTS    = 50,
  parameter int unsigned FIRST_BIT_SLOT = 17
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  irpicd_pkg::in_item_t             in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output irpicd_pkg::out_item_t            out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [irpicd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [irpicd_pkg::IntervalW-1:0] cfg_data_i
);
  import irpicd_pkg::*;

  logic [IntervalW-1:0] start_min_q, start_max_q, one_min_q, one_max_q;
  logic [7:0]           step_q;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      s1_adv, s1_timeout, in_take;

  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;

  logic [7:0] speed_q, speed_d;
  logic       mode_q, mode_d;
  logic [3:0] ind_q, ind_d;

  frame_t     frame;
  logic       fr_valid;
  logic [7:0] cmd;

  // Config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_min_q <= StartMinRst;
      start_max_q <= StartMaxRst;
      one_min_q   <= OneMinRst;
      one_max_q   <= OneMaxRst;
      step_q      <= StepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START_MIN:  start_min_q <= cfg_data_i;
        CFG_START_MAX:  start_max_q <= cfg_data_i;
        CFG_ONE_MIN:    one_min_q   <= cfg_data_i;
        CFG_ONE_MAX:    one_max_q   <= cfg_data_i;
        CFG_SPEED_STEP: step_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  assign s1_timeout = s1_item_q.kind == KindTimeout;
  assign s1_adv     = s1_valid_q && (!s1_timeout || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take || s1_adv) begin
      s1_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
  end

  irpicd_edge_recorder #(
    .FRAME_SLOTS   (FRAME_SLOTS),
    .FIRST_BIT_SLOT(FIRST_BIT_SLOT)
  ) u_recorder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_valid_i   (s1_adv),
    .ev_kind_i    (s1_item_q.kind),
    .ev_interval_i(s1_item_q.interval),
    .one_min_i    (one_min_q),
    .one_max_i    (one_max_q),
    .frame_o      (frame)
  );

  // Command stage
  assign fr_valid = (frame.start_interval >= start_min_q) &&
                    (frame.start_interval <= start_max_q);
  assign cmd      = fr_valid ? frame.bit_classes : 8'd0;

  always_comb begin
    speed_d = speed_q;
    mode_d  = mode_q;
    ind_d   = ind_q;
    if (fr_valid) begin
      case (cmd)
        CmdUp: begin
          ind_d[0] = 1'b1;
          speed_d  = speed_q + step_q;
        end
        CmdDown: begin
          ind_d[1] = 1'b1;
          speed_d  = speed_q - step_q;
        end
        CmdMark: begin
          ind_d[2] = 1'b1;
        end
        CmdMode: begin
          ind_d[3] = 1'b1;
          mode_d   = ~mode_q;
        end
        default: ;
      endcase
    end
  end

  assign out_item_d = '{frame_valid: fr_valid, command: cmd, speed_level: speed_d,
                        run_mode: mode_d, indicators: ind_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= SpeedRst;
      mode_q      <= 1'b0;
      ind_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv && s1_timeout) begin
        speed_q     <= speed_d;
        mode_q      <= mode_d;
        ind_q       <= ind_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_timeout) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `IRPICD_ASSERT(a_result_from_timeout, $rose(out_valid_o) |-> $past(s1_valid_q && s1_timeout), "result without a timeout item")
  `IRPICD_ASSERT(a_invalid_cmd_zero, (out_valid_o && !out_item_o.frame_valid) |-> (out_item_o.command == 8'd0), "invalid frame with non-zero command")
  `IRPICD_ASSERT(a_ind_sticky, 1'b1 |=> ((ind_q & $past(ind_q)) == $past(ind_q)), "indicator bit cleared")
  `IRPICD_ASSERT_ALWAYS(a_stall_needs_item, in_stall_o |-> (s1_valid_q && s1_timeout && out_valid_q), "input stalled without a blocked timeout")

endmodule

FILE: rtl/core/irpicd_edge_recorder.sv
// ----------------------------------------------------------------------------
// IR pulse interval command decoder - edge recorder
// Arms on the first edge, counts slots, keeps the start interval and the
// one-bit classes of the command slots. A timeout clears arm, count and start.
// ----------------------------------------------------------------------------
module irpicd_edge_recorder #(
  parameter int unsigned FRAME_SLOTS    = 50,
  parameter int unsigned FIRST_BIT_SLOT = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              ev_valid_i,
  input  logic                              ev_kind_i,
  input  logic [irpicd_pkg::IntervalW-1:0]  ev_interval_i,
  input  logic [irpicd_pkg::IntervalW-1:0]  one_min_i,
  input  logic [irpicd_pkg::IntervalW-1:0]  one_max_i,
  output irpicd_pkg::frame_t                frame_o
);
  import irpicd_pkg::*;

  localparam logic [SlotW-1:0] FrameSlots = SlotW'(FRAME_SLOTS);
  localparam logic [SlotW-1:0] FirstSlot  = SlotW'(FIRST_BIT_SLOT);
  localparam logic [SlotW-1:0] LastSlot   = SlotW'(FIRST_BIT_SLOT + 7);

  logic                 armed_q, armed_d;
  logic [SlotW-1:0]     slot_q, slot_d;
  logic [IntervalW-1:0] start_q, start_d;
  logic [7:0]           classes_q, classes_d;
  logic [SlotW-1:0]     pos_full;
  logic                 is_one;

  assign pos_full = slot_q - FirstSlot;
  assign is_one   = (ev_interval_i >= one_min_i) && (ev_interval_i <= one_max_i);

  always_comb begin
    armed_d   = armed_q;
    slot_d    = slot_q;
    start_d   = start_q;
    classes_d = classes_q;
    if (ev_valid_i) begin
      if (ev_kind_i == KindTimeout) begin
        armed_d = 1'b0;
        slot_d  = '0;
        start_d = '0;
      end else if (!armed_q) begin
        armed_d = 1'b1;
      end else if (slot_q < FrameSlots) begin
        if (slot_q == '0) begin
          start_d = ev_interval_i;
        end
        if (slot_q >= FirstSlot && slot_q <= LastSlot) begin
          classes_d[pos_full[2:0]] = is_one;
        end
        slot_d = slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      slot_q    <= '0;
      start_q   <= '0;
      classes_q <= '0;
    end else begin
      armed_q   <= armed_d;
      slot_q    <= slot_d;
      start_q   <= start_d;
      classes_q <= classes_d;
    end
  end

  assign frame_o = '{start_interval: start_q, bit_classes: classes_q};

endmodule

FILE: tb/tb_ir_pulse_interval_command_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse interval command decoder - testbench
// Feeds edge and timeout items through the valid/stall input, predicts each
// frame result (validity, command, speed, mode, sticky indicators) and checks
// every result field by field. Directed header-window and unarmed cases come
// first, then random NEC-style frames, truncated and overlong frames and
// noise under three idle profiles and several register settings.
// ----------------------------------------------------------------------------
module tb_ir_pulse_interval_command_decoder;
  import irpicd_pkg::*;

  localparam int unsigned FrameSlots   = 50;
  localparam int unsigned FirstBitSlot = 17;
  localparam logic [IntervalW-1:0] MaxIvl   = 20'd1000000;
  localparam logic [CfgIdxW-1:0]   CfgSpare = 3'd7;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned PhaseItems   = 550;

  typedef enum logic [1:0] {
    SendLight,
    SendHeavy,
    NoIdle
  } idle_mode_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i  = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [IntervalW-1:0] cfg_data_i  = '0;

  // predictor state and register copy
  logic                 frame_armed = 1'b0;
  logic [SlotW-1:0]     slot_cnt    = '0;
  logic [IntervalW-1:0] hdr_ivl     = '0;
  logic [7:0]           cmd_bits    = '0;
  logic [7:0]           speed_q     = SpeedRst;
  logic                 mode_q      = 1'b0;
  logic [3:0]           ind_q       = '0;
  logic [IntervalW-1:0] hdr_lo      = StartMinRst;
  logic [IntervalW-1:0] hdr_hi      = StartMaxRst;
  logic [IntervalW-1:0] mark_lo     = OneMinRst;
  logic [IntervalW-1:0] mark_hi     = OneMaxRst;
  logic [7:0]           step_sz     = StepRst;

  logic [IntervalW-1:0] int_hdr_probe[5] = '{StartMinRst, StartMaxRst, StartMinRst - 1'b1,
                                            StartMaxRst + 1'b1, MaxIvl};

  in_item_t  ir_events[$];
  out_item_t expected_frames[$];

  idle_mode_e  idle_mode   = SendLight;
  int unsigned tx_idle_pct = 12;
  int unsigned rx_idle_pct = 67;
  logic        in_taken    = 1'b0;
  logic        hold_done   = 1'b0;
  int unsigned hold_left   = 0;

  int unsigned pushed_events = 0;
  int unsigned events_taken  = 0;
  int unsigned frames_seen   = 0;
  int unsigned valid_frames  = 0;
  int unsigned error_cnt     = 0;

  ir_pulse_interval_command_decoder #(
    .FRAME_SLOTS   (FrameSlots),
    .FIRST_BIT_SLOT(FirstBitSlot)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic decode_item(input in_item_t it);
    out_item_t res;
    logic      hit;
    if (it.kind == KindEdge) begin
      if (!frame_armed) begin
        frame_armed = 1'b1;
      end else if (slot_cnt < FrameSlots) begin
        if (slot_cnt == 0) hdr_ivl = it.interval;
        if (slot_cnt >= FirstBitSlot && slot_cnt < FirstBitSlot + 8)
          cmd_bits[slot_cnt - FirstBitSlot] = (it.interval >= mark_lo) &&
                                              (it.interval <= mark_hi);
        slot_cnt = slot_cnt + 1'b1;
      end
    end else begin
      hit = (hdr_ivl >= hdr_lo) && (hdr_ivl <= hdr_hi);
      res = '0;
      res.frame_valid = hit;
      if (hit) begin
        res.command = cmd_bits;
        case (cmd_bits)
          CmdUp: begin
            ind_q[0] = 1'b1;
            speed_q  = speed_q + step_sz;
          end
          CmdDown: begin
            ind_q[1] = 1'b1;
            speed_q  = speed_q - step_sz;
          end
          CmdMark: ind_q[2] = 1'b1;
          CmdMode: begin
            ind_q[3] = 1'b1;
            mode_q   = ~mode_q;
          end
          default: ;
        endcase
      end
      res.speed_level = speed_q;
      res.run_mode    = mode_q;
      res.indicators  = ind_q;
      expected_frames.push_back(res);
      frame_armed = 1'b0;
      hdr_ivl     = '0;
      slot_cnt    = '0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      error_cnt++;
    end
  endtask

  // sample both sides at the rising edge
  always @(posedge clk_i) begin
    out_item_t want;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      frames_seen++;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item_o);
        error_cnt++;
      end else begin
        want = expected_frames.pop_front();
        if (want.frame_valid) valid_frames++;
        check_field("frame_valid", want.frame_valid, out_item_o.frame_valid);
        check_field("command", want.command, out_item_o.command);
        check_field("speed_level", want.speed_level, out_item_o.speed_level);
        check_field("run_mode", want.run_mode, out_item_o.run_mode);
        check_field("indicators", want.indicators, out_item_o.indicators);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      decode_item(in_item_i);
      events_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (ir_events.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid_i <= 1'b1;
        in_item_i  <= ir_events.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // one long hold-off at the start of the no-idle profile fills the block
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_mode == NoIdle && !hold_done) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic push_event(input logic kind, input logic [IntervalW-1:0] ivl,
                            input bit counted);
    in_item_t it;
    it.kind     = kind;
    it.interval = ivl;
    ir_events.push_back(it);
    if (counted) pushed_events++;
  endtask

  function automatic logic [IntervalW-1:0] any_ivl();
    return IntervalW'($urandom_range(MaxIvl, 0));
  endfunction

  function automatic logic [IntervalW-1:0] one_ivl();
    if (mark_lo > mark_hi) return any_ivl();
    return IntervalW'($urandom_range(mark_hi, mark_lo));
  endfunction

  function automatic logic [IntervalW-1:0] zero_ivl();
    if (mark_lo > mark_hi) return any_ivl();
    if (mark_lo > 0 && (mark_hi == MaxIvl || $urandom_range(1) == 0))
      return IntervalW'($urandom_range(int'(mark_lo) - 1, 0));
    if (mark_hi < MaxIvl) return IntervalW'($urandom_range(MaxIvl, int'(mark_hi) + 1));
    return '0;
  endfunction

  function automatic logic [IntervalW-1:0] header_ivl();
    case ($urandom_range(9))
      0: return hdr_lo;
      1: return hdr_hi;
      2: return (hdr_lo > 0) ? hdr_lo - 1'b1 : hdr_lo;
      3: return (hdr_hi < MaxIvl) ? hdr_hi + 1'b1 : hdr_hi;
      4: return any_ivl();
      default: begin
        if (hdr_lo > hdr_hi) return any_ivl();
        return IntervalW'($urandom_range(hdr_hi, hdr_lo));
      end
    endcase
  endfunction

  task automatic push_frame();
    logic [7:0]  cmd;
    int unsigned n_edges;
    case ($urandom_range(9))
      0, 1:    cmd = CmdUp;
      2, 3:    cmd = CmdDown;
      4:       cmd = CmdMark;
      5, 6:    cmd = CmdMode;
      default: cmd = 8'($urandom_range(255));
    endcase
    case ($urandom_range(19))
      0, 1:    n_edges = $urandom_range(FrameSlots + 13, FrameSlots);
      2, 3, 4: n_edges = $urandom_range(FirstBitSlot + 7, 0);
      default: n_edges = FirstBitSlot + 8 + $urandom_range(12);
    endcase
    push_event(KindEdge, any_ivl(), 1'b1);
    for (int unsigned s = 0; s < n_edges; s++) begin
      if (s == 0)
        push_event(KindEdge, header_ivl(), 1'b1);
      else if (s >= FirstBitSlot && s < FirstBitSlot + 8)
        push_event(KindEdge, cmd[s - FirstBitSlot] ? one_ivl() : zero_ivl(), 1'b1);
      else
        push_event(KindEdge, ($urandom_range(3) == 0) ? any_ivl() : zero_ivl(),
                   s < FrameSlots);
    end
    push_event(KindTimeout, any_ivl(), 1'b1);
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned goal;
    goal = pushed_events + n_items;
    while (pushed_events < goal) begin
      if ($urandom_range(99) < 80) begin
        push_frame();
      end else begin
        repeat ($urandom_range(6, 1))
          push_event(logic'($urandom_range(1)), any_ivl(), 1'b1);
      end
    end
  endtask

  task automatic wait_idle();
    while (ir_events.size() != 0 || in_valid_i || expected_frames.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [IntervalW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_START_MIN:  hdr_lo  = val;
      CFG_START_MAX:  hdr_hi  = val;
      CFG_ONE_MIN:    mark_lo = val;
      CFG_ONE_MAX:    mark_hi = val;
      CFG_SPEED_STEP: step_sz = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_windows(input logic [IntervalW-1:0] s_lo, input logic [IntervalW-1:0] s_hi,
                             input logic [IntervalW-1:0] o_lo, input logic [IntervalW-1:0] o_hi,
                             input logic [7:0] step);
    cfg_write(CFG_START_MIN, s_lo);
    cfg_write(CFG_START_MAX, s_hi);
    cfg_write(CFG_ONE_MIN, o_lo);
    cfg_write(CFG_ONE_MAX, o_hi);
    cfg_write(CFG_SPEED_STEP, {12'd0, step});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_profile(input idle_mode_e m);
    idle_mode = m;
    case (m)
      SendLight: begin
        tx_idle_pct = 12;
        rx_idle_pct = 67;
      end
      SendHeavy: begin
        tx_idle_pct = 67;
        rx_idle_pct = 12;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // timeout before any edge, then arm-only, then header window bounds
    push_event(KindTimeout, MaxIvl, 1'b1);
    push_event(KindEdge, '0, 1'b1);
    push_event(KindTimeout, '0, 1'b1);
    foreach (int_hdr_probe[i]) begin
      push_event(KindEdge, MaxIvl, 1'b1);
      push_event(KindEdge, int_hdr_probe[i], 1'b1);
      push_event(KindTimeout, '0, 1'b1);
    end
    wait_idle();

    // reversed windows never match; spare index is dropped
    cfg_write(CfgSpare, 20'hFFFFF);
    set_windows(StartMaxRst, StartMinRst, OneMaxRst, OneMinRst, StepRst);
    push_event(KindEdge, '0, 1'b1);
    push_event(KindEdge, 20'd12000, 1'b1);
    push_event(KindTimeout, MaxIvl, 1'b1);
    wait_idle();

    set_windows('0, MaxIvl, '0, 20'd1200, 8'd255);
    set_profile(SendLight);
    run_random(PhaseItems);
    wait_idle();

    set_windows(20'd9000, 20'd13500, 20'd1690, 20'd2250, 8'd0);
    set_profile(SendHeavy);
    run_random(PhaseItems);
    wait_idle();

    set_windows(20'd600000, MaxIvl, 20'd999000, MaxIvl, 8'd128);
    set_profile(NoIdle);
    run_random(PhaseItems);
    wait_idle();

    $display("Run covered %0d items under three idle profiles and five register settings,",
             events_taken);
    $display("with %0d frame results checked, %0d of them valid, and %0d field errors.",
             frames_seen, valid_frames, error_cnt);
    if (error_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
